### rtl/emot_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the extent map offset translator.
// Depends on nothing; every other file imports it.
package emot_pkg;

	localparam int unsigned ADDR_W = 48;
	localparam int unsigned ALU_W = 50;
	localparam int unsigned CHUNK_CNT_W = 7;
	localparam logic [CHUNK_CNT_W-1:0] MAX_CHUNKS = 7'd64;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;

	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic [1:0] op;
		logic [ADDR_W-1:0] logical_offset;
		logic [ADDR_W-1:0] physical_offset;
		logic [ADDR_W-1:0] span_length;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] physical_addr;
		logic [ADDR_W-1:0] chunk_len;
		logic [ADDR_W-1:0] request_pos;
		logic [ADDR_W-1:0] accepted_len;
		logic last;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] logical_start;
		logic [ADDR_W-1:0] physical_start;
		logic [ADDR_W-1:0] extent_length;
	} entry_t;

endpackage

### rtl/emot_table.sv
`timescale 1ns / 1ps
// Extent table memory: one write port and one read port with registered read data.
// Depends on emot_pkg for the entry type.
module emot_table import emot_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  entry_t wdata,
	input  logic re,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output entry_t rdata
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/emot_alu.sv
`timescale 1ns / 1ps
// Shared add/subtract unit used by the sequencer for its total, search and extent-end compares and address sums.
// Depends on emot_pkg for its width and mode codes.
module emot_alu import emot_pkg::*; (
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	input  logic mode,
	output logic [ALU_W-1:0] y
);

	always_comb begin
		case (mode)
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

endmodule

### rtl/emot_seq.sv
`timescale 1ns / 1ps
// Sequencer: table bookkeeping, binary search and chunk walk over the shared ALU.
// Depends on emot_pkg and emot_alu; drives the table ports of emot_table.
module emot_seq import emot_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic idle,
	input  logic can_put,
	output logic put,
	output rsp_t put_data,
	output logic tbl_we,
	output logic [$clog2(ENTRIES)-1:0] tbl_waddr,
	output entry_t tbl_wdata,
	output logic tbl_re,
	output logic [$clog2(ENTRIES)-1:0] tbl_raddr,
	input  entry_t tbl_rdata
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned SW = $clog2(ENTRIES + 2) + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OP = 4'd1;
	localparam logic [3:0] S_STEP = 4'd2;
	localparam logic [3:0] S_CMP = 4'd3;
	localparam logic [3:0] S_FETCH = 4'd4;
	localparam logic [3:0] S_END = 4'd5;
	localparam logic [3:0] S_LOOP = 4'd6;
	localparam logic [3:0] S_PA1 = 4'd7;
	localparam logic [3:0] S_PA2 = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;
	localparam logic [3:0] S_GAP = 4'd10;
	localparam logic [3:0] S_FINAL = 4'd11;

	logic [3:0] state_q;
	logic [1:0] op_q;
	logic [ADDR_W:0] off_q;
	logic [ADDR_W-1:0] po_q;
	logic [ADDR_W-1:0] rem_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W:0] end_q;
	logic [ADDR_W-1:0] chunk_q;
	logic [ADDR_W-1:0] tmp_q;
	logic [ADDR_W-1:0] pa_q;
	logic signed [SW-1:0] base_q;
	logic [SW-1:0] delta_q;
	logic signed [SW-1:0] next_q;
	logic signed [SW-1:0] idx_q;
	logic [CHUNK_CNT_W-1:0] n_q;
	logic pend_v_q;
	logic [ADDR_W-1:0] pend_pa_q;
	logic [ADDR_W-1:0] pend_len_q;
	logic [ADDR_W-1:0] pend_pos_q;
	logic [ADDR_W-1:0] acc_q;
	logic [1:0] status_q;
	logic [CW-1:0] count_q;
	logic [ADDR_W-1:0] total_q;

	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic alu_mode;
	logic [ALU_W-1:0] alu_y;
	logic alu_neg;
	logic alu_zero;

	logic [SW-1:0] delta_nx;
	logic signed [SW-1:0] next_c;
	logic signed [SW-1:0] idx_inc;
	logic signed [SW-1:0] count_s;
	logic in_tab;
	logic [ADDR_W-1:0] loop_chunk;
	logic [ADDR_W-1:0] gap_chunk;
	logic [ADDR_W-1:0] clamp_len;

	emot_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.mode(alu_mode),
		.y(alu_y)
	);

	assign alu_neg = alu_y[ALU_W-1];
	assign alu_zero = (alu_y == '0);
	assign idle = (state_q == S_IDLE);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_mode = ALU_ADD;
		case (state_q)
			S_OP: begin
				alu_a = ALU_W'(total_q);
				if (op_q == OP_APPEND) begin
					alu_b = ALU_W'(rem_q);
				end else begin
					alu_b = ALU_W'(off_q);
					alu_mode = ALU_SUB;
				end
			end
			S_CMP, S_PA1: begin
				alu_a = ALU_W'(off_q);
				alu_b = ALU_W'(tbl_rdata.logical_start);
				alu_mode = ALU_SUB;
			end
			S_END: begin
				alu_a = ALU_W'(tbl_rdata.logical_start);
				alu_b = ALU_W'(tbl_rdata.extent_length);
			end
			S_LOOP: begin
				alu_a = ALU_W'(end_q);
				alu_b = ALU_W'(off_q);
				alu_mode = ALU_SUB;
			end
			S_PA2: begin
				alu_a = ALU_W'(tbl_rdata.physical_start);
				alu_b = ALU_W'(tmp_q);
			end
			S_GAP: begin
				alu_a = ALU_W'(tbl_rdata.logical_start);
				alu_b = ALU_W'(off_q);
				alu_mode = ALU_SUB;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	always_comb begin
		delta_nx = (delta_q + SW'(1)) >> 1;
		next_c = base_q - $signed(delta_nx);
		idx_inc = idx_q + SW'(1);
		count_s = SW'(count_q);
		in_tab = (idx_inc < count_s);
		// The positive difference is at most 49 bits; compare against the remainder.
		loop_chunk = (alu_y[ADDR_W:0] > {1'b0, rem_q}) ? rem_q : alu_y[ADDR_W-1:0];
		// A start below the current offset behaves as an endless gap.
		gap_chunk = (!alu_neg && (alu_y[ADDR_W:0] < {1'b0, rem_q})) ?
			alu_y[ADDR_W-1:0] : rem_q;
		clamp_len = (rem_q > alu_y[ADDR_W-1:0]) ? alu_y[ADDR_W-1:0] : rem_q;
	end

	always_comb begin
		tbl_we = (state_q == S_OP) && (op_q == OP_APPEND) && (count_q < CW'(ENTRIES));
		tbl_waddr = count_q[IW-1:0];
		tbl_wdata.logical_start = off_q[ADDR_W-1:0];
		tbl_wdata.physical_start = po_q;
		tbl_wdata.extent_length = rem_q;
		tbl_re = 1'b0;
		tbl_raddr = idx_q[IW-1:0];
		case (state_q)
			S_STEP: begin
				tbl_re = (delta_q > SW'(1)) && !next_c[SW-1];
				tbl_raddr = next_c[IW-1:0];
			end
			S_FETCH: begin
				tbl_re = !idx_q[SW-1];
			end
			S_LOOP: begin
				tbl_re = (rem_q != '0) && (alu_neg || alu_zero) && in_tab;
				tbl_raddr = idx_inc[IW-1:0];
			end
			default: begin
				tbl_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		put = 1'b0;
		put_data.physical_addr = pend_pa_q;
		put_data.chunk_len = pend_len_q;
		put_data.request_pos = pend_pos_q;
		put_data.accepted_len = '0;
		put_data.last = 1'b0;
		put_data.status = ST_OK;
		case (state_q)
			S_EMIT: begin
				put = pend_v_q && can_put;
			end
			S_FINAL: begin
				put = can_put;
				put_data.accepted_len = acc_q;
				put_data.last = 1'b1;
				put_data.status = status_q;
			end
			default: begin
				put = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.op;
						off_q <= {1'b0, req.logical_offset};
						po_q <= req.physical_offset;
						rem_q <= req.span_length;
						state_q <= S_OP;
					end
				end
				S_OP: begin
					pend_v_q <= 1'b0;
					pend_pa_q <= '0;
					pend_len_q <= '0;
					pend_pos_q <= '0;
					n_q <= '0;
					pos_q <= '0;
					acc_q <= '0;
					status_q <= ST_OK;
					base_q <= SW'(count_q);
					delta_q <= SW'(count_q) + SW'(1);
					case (op_q)
						OP_CLEAR: begin
							count_q <= '0;
							total_q <= '0;
							state_q <= S_FINAL;
						end
						OP_APPEND: begin
							if (count_q >= CW'(ENTRIES)) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
								total_q <= alu_y[ADDR_W] ? '1 : alu_y[ADDR_W-1:0];
							end
							state_q <= S_FINAL;
						end
						OP_READ: begin
							if (alu_neg || alu_zero) begin
								status_q <= ST_BEYOND;
								state_q <= S_FINAL;
							end else begin
								rem_q <= clamp_len;
								state_q <= S_STEP;
							end
						end
						default: begin
							state_q <= S_STEP;
						end
					endcase
				end
				S_STEP: begin
					if (delta_q > SW'(1)) begin
						delta_q <= delta_nx;
						if (!next_c[SW-1]) begin
							next_q <= next_c;
							state_q <= S_CMP;
						end
					end else begin
						idx_q <= base_q - SW'(1);
						state_q <= S_FETCH;
					end
				end
				S_CMP: begin
					if (alu_neg) begin
						base_q <= next_q;
					end
					state_q <= S_STEP;
				end
				S_FETCH: begin
					if (!idx_q[SW-1]) begin
						state_q <= S_END;
					end else begin
						end_q <= '0;
						state_q <= S_LOOP;
					end
				end
				S_END: begin
					end_q <= alu_y[ADDR_W:0];
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (rem_q == '0) begin
						acc_q <= pos_q;
						state_q <= S_FINAL;
					end else if (!alu_neg && !alu_zero) begin
						if (n_q == MAX_CHUNKS) begin
							acc_q <= pos_q;
							state_q <= S_FINAL;
						end else begin
							chunk_q <= loop_chunk;
							state_q <= S_PA1;
						end
					end else begin
						idx_q <= idx_inc;
						if (in_tab) begin
							state_q <= S_GAP;
						end else begin
							// Past the last extent: the rest of the request is unmapped.
							off_q <= off_q + {1'b0, rem_q};
							pos_q <= pos_q + rem_q;
							rem_q <= '0;
						end
					end
				end
				S_PA1: begin
					tmp_q <= alu_y[ADDR_W-1:0];
					state_q <= S_PA2;
				end
				S_PA2: begin
					pa_q <= alu_y[ADDR_W-1:0];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// The previous chunk is held back until we know it is not the last.
					if (!pend_v_q || can_put) begin
						pend_v_q <= 1'b1;
						pend_pa_q <= pa_q;
						pend_len_q <= chunk_q;
						pend_pos_q <= pos_q;
						n_q <= n_q + CHUNK_CNT_W'(1);
						off_q <= off_q + {1'b0, chunk_q};
						pos_q <= pos_q + chunk_q;
						rem_q <= rem_q - chunk_q;
						state_q <= S_LOOP;
					end
				end
				S_GAP: begin
					off_q <= off_q + {1'b0, gap_chunk};
					pos_q <= pos_q + gap_chunk;
					rem_q <= rem_q - gap_chunk;
					state_q <= S_END;
				end
				S_FINAL: begin
					if (can_put) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/extent_map_offset_translator.sv
`timescale 1ns / 1ps
// Channel  Signals                     Direction  Carries
// req      req_valid, req_stall, req   in         one command or request word (req_t)
// rsp      rsp_valid, rsp_stall, rsp   out        one chunk or completion word (rsp_t)
//
// Clear, append and a read beyond the mapped total go from S_OP straight to S_FINAL,
// which puts their result word. A write or read makes ceil(log2(count+1)) search steps
// through S_STEP and S_CMP (S_STEP alone where the probe falls below the table), then
// each chunk passes S_LOOP, S_PA1, S_PA2 and S_EMIT and each skipped gap S_LOOP, S_GAP
// and S_END, all through the single shared ALU and table read port. Reset empties the
// table at once; there is no clearing pass. A word waits in the output register under
// rsp_stall; req_stall is high whenever a request is being worked on.
// Depends on emot_pkg, emot_seq, emot_alu and emot_table.
module extent_map_offset_translator import emot_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned IW = $clog2(ENTRIES);

	logic idle;
	logic can_put;
	logic put;
	rsp_t put_data;
	logic tbl_we;
	logic [IW-1:0] tbl_waddr;
	entry_t tbl_wdata;
	logic tbl_re;
	logic [IW-1:0] tbl_raddr;
	entry_t tbl_rdata;
	logic rsp_valid_q;
	rsp_t rsp_q;

	emot_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re(tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	emot_seq #(
		.ENTRIES(ENTRIES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.idle(idle),
		.can_put(can_put),
		.put(put),
		.put_data(put_data),
		.tbl_we(tbl_we),
		.tbl_waddr(tbl_waddr),
		.tbl_wdata(tbl_wdata),
		.tbl_re(tbl_re),
		.tbl_raddr(tbl_raddr),
		.tbl_rdata(tbl_rdata)
	);

	assign req_stall = !idle;
	assign can_put = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (put) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			rsp_q <= put_data;
		end
	end

endmodule

### tb/sv/emot_chunk_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the extent map offset translator, predicts the result words
// that each request word should produce and compares them with what comes out.
// Depends on emot_pkg for the word types, operation codes and status codes.
module emot_chunk_checker import emot_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatch_count,
	output int   chunks_outstanding
);

	logic [ADDR_W-1:0] map_logical [ENTRIES];
	logic [ADDR_W-1:0] map_physical [ENTRIES];
	logic [ADDR_W-1:0] map_length [ENTRIES];
	int map_count;
	logic [ADDR_W-1:0] map_total;
	rsp_t expected_chunks[$];
	int fail_total = 0;

	function automatic void expect_word(input logic [ADDR_W-1:0] pa, input logic [ADDR_W-1:0] len,
			input logic [ADDR_W-1:0] pos, input logic [ADDR_W-1:0] acc, input logic last,
			input logic [1:0] st);
		rsp_t w;
		w.physical_addr = pa;
		w.chunk_len = len;
		w.request_pos = pos;
		w.accepted_len = acc;
		w.last = last;
		w.status = st;
		expected_chunks.push_back(w);
	endfunction

	// Index of the last extent whose start is not above off, for an ordered table;
	// minus one if there is none.
	function automatic int find_extent(input logic [63:0] off);
		int base;
		int delta;
		int next;
		base = map_count;
		delta = base + 1;
		while (delta > 1) begin
			delta = (delta + 1) / 2;
			next = base - delta;
			if (next >= 0 && next < map_count && off < {16'd0, map_logical[next]})
				base = next;
		end
		return base - 1;
	endfunction

	// The walk runs in 64 bits, so extent ends above the address range do not wrap.
	function automatic void split_request(input logic [63:0] start, input logic [63:0] count);
		int idx;
		int produced;
		logic [63:0] off;
		logic [63:0] stop;
		logic [63:0] pos;
		logic [63:0] rem;
		logic [63:0] piece;
		logic [63:0] gap;
		logic [63:0] pa;
		rsp_t w;
		idx = find_extent(start);
		off = start;
		stop = '0;
		pos = '0;
		rem = count;
		produced = 0;
		if (idx >= 0)
			stop = {16'd0, map_logical[idx]} + {16'd0, map_length[idx]};
		while (rem != 0) begin
			if (off < stop) begin
				if (produced == int'(MAX_CHUNKS))
					break;
				piece = stop - off;
				if (piece > rem)
					piece = rem;
				pa = {16'd0, map_physical[idx]} + (off - {16'd0, map_logical[idx]});
				expect_word(pa[ADDR_W-1:0], piece[ADDR_W-1:0], pos[ADDR_W-1:0], '0, 1'b0, ST_OK);
				produced++;
			end else begin
				piece = rem;
				idx++;
				if (idx < map_count) begin
					gap = {16'd0, map_logical[idx]} - off;
					stop = {16'd0, map_logical[idx]} + {16'd0, map_length[idx]};
					if (piece > gap)
						piece = gap;
				end
			end
			off += piece;
			pos += piece;
			rem -= piece;
		end
		if (produced == 0) begin
			expect_word('0, '0, '0, pos[ADDR_W-1:0], 1'b1, ST_OK);
		end else begin
			w = expected_chunks.pop_back();
			w.accepted_len = pos[ADDR_W-1:0];
			w.last = 1'b1;
			expected_chunks.push_back(w);
		end
	endfunction

	function automatic void predict_word(input req_t w);
		logic [ADDR_W:0] sum;
		logic [ADDR_W-1:0] room;
		logic [ADDR_W-1:0] span;
		case (w.op)
			OP_CLEAR: begin
				map_count = 0;
				map_total = '0;
				expect_word('0, '0, '0, '0, 1'b1, ST_OK);
			end
			OP_APPEND: begin
				if (map_count >= ENTRIES) begin
					expect_word('0, '0, '0, '0, 1'b1, ST_FULL);
				end else begin
					map_logical[map_count] = w.logical_offset;
					map_physical[map_count] = w.physical_offset;
					map_length[map_count] = w.span_length;
					map_count++;
					// The mapped total saturates rather than wrapping.
					sum = {1'b0, map_total} + {1'b0, w.span_length};
					map_total = sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
					expect_word('0, '0, '0, '0, 1'b1, ST_OK);
				end
			end
			OP_WRITE: begin
				split_request({16'd0, w.logical_offset}, {16'd0, w.span_length});
			end
			OP_READ: begin
				if (w.logical_offset >= map_total) begin
					expect_word('0, '0, '0, '0, 1'b1, ST_BEYOND);
				end else begin
					room = map_total - w.logical_offset;
					span = (w.span_length > room) ? room : w.span_length;
					split_request({16'd0, w.logical_offset}, {16'd0, span});
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int field_differs(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want === got)
			return 0;
		$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int bad;
		if (!arst_n) begin
			map_count = 0;
			map_total = '0;
			expected_chunks.delete();
			mismatch_count <= fail_total;
			chunks_outstanding <= 0;
		end else begin
			// Results are checked before the request at the same edge is predicted,
			// since a word cannot answer a request accepted at that very edge.
			if (rsp_valid && !rsp_stall) begin
				if (expected_chunks.size() == 0) begin
					$display("%0t unexpected result word: expected none, actual %h", $time, rsp);
					fail_total++;
				end else begin
					want = expected_chunks.pop_front();
					bad = 0;
					bad += field_differs("physical_addr", want.physical_addr, rsp.physical_addr);
					bad += field_differs("chunk_len", want.chunk_len, rsp.chunk_len);
					bad += field_differs("request_pos", want.request_pos, rsp.request_pos);
					bad += field_differs("accepted_len", want.accepted_len, rsp.accepted_len);
					bad += field_differs("last", {47'd0, want.last}, {47'd0, rsp.last});
					bad += field_differs("status", {46'd0, want.status}, {46'd0, rsp.status});
					if (bad != 0)
						fail_total++;
				end
			end
			if (req_valid && !req_stall)
				predict_word(req);
			mismatch_count <= fail_total;
			chunks_outstanding <= expected_chunks.size();
		end
	end

endmodule

### tb/sv/tb_extent_map_offset_translator.sv
`timescale 1ns / 1ps
// Top of the extent map offset translator testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on emot_pkg, the block and emot_chunk_checker.
module tb_extent_map_offset_translator;
	import emot_pkg::*;

	localparam int MAX_CYCLES = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 310;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int items_sent = 0;
	int cycle_count = 0;
	bit hold_go = 1'b0;

	always #4 clk = ~clk;

	extent_map_offset_translator #(.ENTRIES(64)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	emot_chunk_checker #(.ENTRIES(64)) i_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.req                (req),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.rsp                (rsp),
		.mismatch_count     (mismatches),
		.chunks_outstanding (outstanding)
	);

	function automatic logic [ADDR_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[ADDR_W-1:0];
	endfunction

	// Offers one word and returns at the edge that takes it, after any idle cycles.
	task automatic send_word(input logic [1:0] op, input logic [ADDR_W-1:0] lo,
			input logic [ADDR_W-1:0] po, input logic [ADDR_W-1:0] sl);
		req_t w;
		w.op = op;
		w.logical_offset = lo;
		w.physical_offset = po;
		w.span_length = sl;
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Response side back-pressure, with an occasional long hold-off on request.
	initial begin
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin
		while (cycle_count < MAX_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int session;
		int n_ext;
		int n_req;
		int k;
		int unsigned cursor;
		int unsigned gap;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] len;
		logic [1:0] op;
		bit ordered;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 23;
		rx_idle_pct = 77;

		// Empty table: a read lies beyond the mapped data, writes map nothing.
		send_word(OP_READ, '0, '0, 48'h10);
		send_word(OP_WRITE, '1, '1, '1);
		send_word(OP_WRITE, '0, '0, '0);
		// An extent whose physical range wraps, a zero-length one and one after a gap.
		send_word(OP_APPEND, '0, 48'hFFFF_FFFF_FF80, 48'h100);
		send_word(OP_APPEND, 48'h100, 48'h123, '0);
		send_word(OP_APPEND, 48'h180, 48'h8000, 48'h200);
		send_word(OP_WRITE, '0, '0, 48'h1000);
		send_word(OP_READ, 48'h40, '0, '1);
		send_word(OP_READ, 48'h300, '0, 48'h1);
		send_word(OP_READ, 48'h2FF, '0, 48'h1);
		send_word(OP_READ, '0, '0, '0);
		send_word(OP_WRITE, '1, '0, '1);
		send_word(OP_WRITE, 48'hF0, '0, 48'h20);
		// A huge extent saturates the mapped total.
		send_word(OP_APPEND, 48'h400, '0, '1);
		send_word(OP_READ, 48'hFFFF_FFFF_FFFE, '0, 48'hFF);
		// An extent out of logical order.
		send_word(OP_APPEND, 48'h300, 48'hABC, 48'h10);
		send_word(OP_WRITE, 48'h150, '0, 48'h400);
		send_word(OP_CLEAR, '1, '1, '1);
		send_word(OP_READ, '0, '0, 48'h1);
		send_word(OP_APPEND, '0, '0, '0);
		send_word(OP_WRITE, '0, '0, 48'h10);
		send_word(OP_READ, '0, '0, 48'h10);
		send_word(OP_CLEAR, '0, '0, '0);

		session = 0;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent < 110) begin
				tx_idle_pct = 23;
				rx_idle_pct = 77;
			end else if (items_sent < 220) begin
				tx_idle_pct = 77;
				rx_idle_pct = 23;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			session++;
			if (session == 3)
				drain_results();
			if ($urandom_range(9) != 0)
				send_word(OP_CLEAR, rand48(), rand48(), rand48());

			// Mostly small tables; now and then one that fills up and may overflow.
			if (session == 2 || $urandom_range(14) == 0)
				n_ext = $urandom_range(64, 66);
			else
				n_ext = $urandom_range(1, 8);
			cursor = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 'h100);
			for (k = 0; k < n_ext; k++) begin
				gap = $urandom_range(1) ? 0 : $urandom_range(1, 'h80);
				len = ($urandom_range(7) == 0) ? '0 : ADDR_W'($urandom_range(1, 'h400));
				lo = ADDR_W'(cursor + gap);
				ordered = 1'b1;
				if ($urandom_range(11) == 0) begin
					lo = rand48();
					ordered = 1'b0;
				end
				if ($urandom_range(19) == 0) begin
					len = rand48();
					ordered = 1'b0;
				end
				if (ordered)
					cursor = cursor + gap + int'(len);
				send_word(OP_APPEND, lo, rand48(), len);
			end

			// The response side holds off while requests keep coming.
			if (session == 2)
				hold_go = ~hold_go;
			n_req = (session == 2) ? 8 : $urandom_range(2, 6);
			for (k = 0; k < n_req; k++) begin
				if ($urandom_range(7) == 0) begin
					op = 2'($urandom_range(3));
					send_word(op, rand48(), rand48(), rand48());
				end else begin
					op = $urandom_range(1) ? OP_WRITE : OP_READ;
					lo = ADDR_W'($urandom_range(0, cursor));
					case ($urandom_range(4))
						0: len = '0;
						1: len = rand48();
						2: begin
							// Span the whole table from its start.
							lo = '0;
							len = ADDR_W'(cursor + 'h200);
						end
						default: len = ADDR_W'($urandom_range(1, 'h2000));
					endcase
					send_word(op, lo, rand48(), len);
				end
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
